// File: hdl/fbr_pkg.sv
// Shared types and constants for the framed byte receiver.
// Holds parse phases, result codes, register indexes and the result record.
// No dependencies.
package fbr_pkg;

   localparam logic [7:0] HEADER_BYTE = 8'hAA;

   localparam logic [7:0] OWN_ADDRESS_RESET       = 8'd97;
   localparam logic [7:0] BROADCAST_ADDRESS_RESET = 8'd255;
   localparam logic [7:0] LENGTH_LIMIT_RESET      = 8'd250;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_OWN_ADDRESS       = 2'd0;
   localparam csr_index_type CSR_BROADCAST_ADDRESS = 2'd1;
   localparam csr_index_type CSR_LENGTH_LIMIT      = 2'd2;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_PAYLOAD   = 2'd0;
   localparam kind_type KIND_GOOD      = 2'd1;
   localparam kind_type KIND_SUM_ERROR = 2'd2;

   typedef enum logic [2:0] {
      PHASE_HUNT,
      PHASE_DEST,
      PHASE_CMD,
      PHASE_LEN,
      PHASE_PAYLOAD,
      PHASE_CHECK1,
      PHASE_CHECK2
   } phase_type;

   typedef struct packed {
      logic [7:0] own_address;
      logic [7:0] broadcast_address;
      logic [7:0] length_limit;
   } cfg_type;

   typedef struct packed {
      kind_type   result_kind;
      logic [7:0] frame_command;
      logic [7:0] destination;
      logic [7:0] payload_value;
      logic [7:0] payload_index;
      logic [7:0] payload_length;
      logic [7:0] sum_check;
      logic [7:0] add_check;
   } result_type;

endpackage

// File: hdl/framed_byte_receiver_dual_sum_check_unit.sv
// Top level of the framed byte receiver with byte sum and sum-of-sums check.
// Depends on fbr_pkg, fbr_input_stage, fbr_parser and fbr_output_reg.
//
//   channel | direction | handshake              | carries
//   --------+-----------+------------------------+-----------------------------
//   req_    | in        | req_valid / req_stall  | req_rx_byte
//   rsp_    | out       | rsp_valid / rsp_stall  | kind, command, dest, payload,
//           |           |                        | index, length, both sums
//   csr_    | in        | csr_valid / csr_ready  | csr_index, csr_wdata
//
// One byte a cycle while no result is stalled: a byte is held in the input
// register, the parser updates phase and sums in a single pass, and any result
// is then registered in the result register. Synchronous reset returns the
// parser to hunting and empties both registers. A stalled result holds the
// input register; rsp_stall reaches req_stall in the same cycle only while a
// result is waiting.
module framed_byte_receiver_dual_sum_check_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_result_kind,
   output logic [7:0]             rsp_frame_command,
   output logic [7:0]             rsp_destination,
   output logic [7:0]             rsp_payload_value,
   output logic [7:0]             rsp_payload_index,
   output logic [7:0]             rsp_payload_length,
   output logic [7:0]             rsp_sum_check,
   output logic [7:0]             rsp_add_check,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  fbr_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_wdata
);
   import fbr_pkg::*;

   cfg_type    cfg_ff;
   logic       item_valid;
   logic [7:0] item_byte;
   logic       out_ready;
   logic       advance;
   logic       result_valid;
   result_type result;
   result_type rsp_result;

   // configuration writes are always taken; indexes beyond the list drop
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address       <= OWN_ADDRESS_RESET;
         cfg_ff.broadcast_address <= BROADCAST_ADDRESS_RESET;
         cfg_ff.length_limit      <= LENGTH_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS:       cfg_ff.own_address       <= csr_wdata;
            CSR_BROADCAST_ADDRESS: cfg_ff.broadcast_address <= csr_wdata;
            CSR_LENGTH_LIMIT:      cfg_ff.length_limit      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // advance the held byte whenever the result register can take its result
   assign advance = item_valid && out_ready;

   fbr_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .advance     (advance),
      .item_valid  (item_valid),
      .item_byte   (item_byte)
   );

   fbr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .rx_byte      (item_byte),
      .cfg          (cfg_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   fbr_output_reg u_output (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && result_valid),
      .result     (result),
      .out_ready  (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_result_kind    = rsp_result.result_kind;
   assign rsp_frame_command  = rsp_result.frame_command;
   assign rsp_destination    = rsp_result.destination;
   assign rsp_payload_value  = rsp_result.payload_value;
   assign rsp_payload_index  = rsp_result.payload_index;
   assign rsp_payload_length = rsp_result.payload_length;
   assign rsp_sum_check      = rsp_result.sum_check;
   assign rsp_add_check      = rsp_result.add_check;

endmodule

// File: hdl/fbr_input_stage.sv
// Input register of the framed byte receiver: holds one received byte.
// Depends on nothing but the clock and reset.
module fbr_input_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_rx_byte,
   output logic       req_stall,
   input  logic       advance,
   output logic       item_valid,
   output logic [7:0] item_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   // stall only while the held byte cannot move on
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

// File: hdl/fbr_parser.sv
// Frame parser: phase register, running sums and held header fields.
// Uses fbr_pkg for phases, result codes and the result record.
module fbr_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [7:0]         rx_byte,
   input  fbr_pkg::cfg_type   cfg,
   output logic               result_valid,
   output fbr_pkg::result_type result
);
   import fbr_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] position_ff, position_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] sos_ff, sos_in;
   logic [7:0] command_ff, command_in;
   logic [7:0] dest_ff, dest_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] check1_ff, check1_in;
   logic [7:0] acc_sum, acc_sos;

   assign acc_sum = sum_ff + rx_byte;
   assign acc_sos = sos_ff + acc_sum;

   always_comb begin
      phase_in     = PHASE_HUNT;
      remaining_in = remaining_ff;
      position_in  = position_ff;
      sum_in       = sum_ff;
      sos_in       = sos_ff;
      command_in   = command_ff;
      dest_in      = dest_ff;
      length_in    = length_ff;
      check1_in    = check1_ff;
      result_valid = 1'b0;
      result       = '{result_kind:    KIND_PAYLOAD,
                       frame_command:  command_ff,
                       destination:    dest_ff,
                       payload_value:  8'd0,
                       payload_index:  8'd0,
                       payload_length: length_ff,
                       sum_check:      8'd0,
                       add_check:      8'd0};
      unique case (phase_ff)
         PHASE_HUNT: begin
            if (rx_byte == HEADER_BYTE) begin
               phase_in = PHASE_DEST;
               sum_in   = rx_byte;
               sos_in   = rx_byte;
            end
         end
         PHASE_DEST: begin
            if (rx_byte == cfg.own_address || rx_byte == cfg.broadcast_address) begin
               phase_in = PHASE_CMD;
               dest_in  = rx_byte;
               sum_in   = acc_sum;
               sos_in   = acc_sos;
            end
         end
         PHASE_CMD: begin
            phase_in   = PHASE_LEN;
            command_in = rx_byte;
            sum_in     = acc_sum;
            sos_in     = acc_sos;
         end
         PHASE_LEN: begin
            if (rx_byte < cfg.length_limit) begin
               phase_in     = PHASE_PAYLOAD;
               length_in    = rx_byte;
               remaining_in = rx_byte;
               position_in  = 8'd0;
               sum_in       = acc_sum;
               sos_in       = acc_sos;
            end
         end
         PHASE_PAYLOAD: begin
            // a zero length leaves nothing to take: drop the frame
            if (remaining_ff != 8'd0) begin
               sum_in               = acc_sum;
               sos_in               = acc_sos;
               result_valid         = 1'b1;
               result.payload_value = rx_byte;
               result.payload_index = position_ff;
               position_in          = position_ff + 8'd1;
               remaining_in         = remaining_ff - 8'd1;
               phase_in = (remaining_ff == 8'd1) ? PHASE_CHECK1 : PHASE_PAYLOAD;
            end
         end
         PHASE_CHECK1: begin
            phase_in  = PHASE_CHECK2;
            check1_in = rx_byte;
         end
         PHASE_CHECK2: begin
            result_valid       = 1'b1;
            result.result_kind = (check1_ff == sum_ff && rx_byte == sos_ff) ?
                                 KIND_GOOD : KIND_SUM_ERROR;
            result.sum_check   = sum_ff;
            result.add_check   = sos_ff;
         end
         default: begin
            phase_in = PHASE_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HUNT;
      end else if (advance) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         remaining_ff <= remaining_in;
         position_ff  <= position_in;
         sum_ff       <= sum_in;
         sos_ff       <= sos_in;
         command_ff   <= command_in;
         dest_ff      <= dest_in;
         length_ff    <= length_in;
         check1_ff    <= check1_in;
      end
   end

endmodule

// File: hdl/fbr_output_reg.sv
// Result register of the framed byte receiver: holds one result for transfer.
// Uses fbr_pkg for the result record.
module fbr_output_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  fbr_pkg::result_type result,
   output logic               out_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fbr_pkg::result_type rsp_result
);
   import fbr_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule
